>>> rtl/reau_pkg.sv
package reau_pkg;

   typedef enum logic [2:0] {
      KIND_LOAD    = 3'd0,
      KIND_ADD     = 3'd1,
      KIND_SUB     = 3'd2,
      KIND_MUL     = 3'd3,
      KIND_CMP     = 3'd4,
      KIND_INV     = 3'd5,
      KIND_RSVD6   = 3'd6,
      KIND_RSVD7   = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ORDER_LESS    = 2'd0,
      ORDER_EQUAL   = 2'd1,
      ORDER_GREATER = 2'd2
   } order_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_OPGCD,
      ST_OPDIV,
      ST_OPCHK,
      ST_DGCD,
      ST_LCM,
      ST_SUM,
      ST_MUL,
      ST_RGCD,
      ST_RDIV,
      ST_RCHK,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_GCD,
      DIV_QUO
   } div_mode_type;

   typedef struct packed {
      logic         start;
      div_mode_type mode;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

>>> rtl/reau_divider.sv
module reau_divider #(
   parameter int W = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  reau_pkg::div_ctl_type ctl,
   input  logic [W-1:0]         a,
   input  logic [W-1:0]         b,
   output reau_pkg::div_sts_type sts,
   output logic [W-1:0]         quo,
   output logic [W-1:0]         result
);

   localparam int CW = $clog2(W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   reau_pkg::div_mode_type mode_ff, mode_in;
   logic [W-1:0]         x_ff, x_in;
   logic [W-1:0]         y_ff, y_in;
   logic [W-1:0]         q_ff, q_in;
   logic [W-1:0]         r_ff, r_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [W:0]           trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      trial   = {r_ff[W-1:0], q_ff[W-1]} - {1'b0, y_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         x_in    = a;
         y_in    = b;
         q_in    = a;
         r_in    = '0;
         cnt_in  = CW'(W);
         if (ctl.mode == reau_pkg::DIV_GCD && b == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (!trial[W]) begin
               r_in = trial[W-1:0];
               q_in = {q_ff[W-2:0], 1'b1};
            end else begin
               r_in = {r_ff[W-2:0], q_ff[W-1]};
               q_in = {q_ff[W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
         end else if (mode_ff == reau_pkg::DIV_GCD && r_ff != '0) begin
            x_in   = y_ff;
            y_in   = r_ff;
            q_in   = y_ff;
            r_in   = '0;
            cnt_in = CW'(W);
         end else begin
            if (mode_ff == reau_pkg::DIV_GCD) begin
               x_in = y_ff;
            end
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = q_ff;
   assign result   = x_ff;

endmodule

>>> rtl/rational_exponent_accumulator_unit.sv
// An undefined kind or a zero denominator passes from accept straight to ST_DONE;
//   otherwise the result waits on the shared restoring divider, which runs each division
//   or Euclid step in turn, with add and subtract needing the most of them.
// Throughput: one item at a time; req_ready is low until the result is taken.
// Reset: synchronous, active high; accumulator clears to 0/1, not contributing.
module rational_exponent_accumulator_unit #(
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_kind,
   input  logic signed [VALUE_BITS-1:0] req_op_numer,
   input  logic signed [VALUE_BITS-1:0] req_op_denom,
   input  logic                  req_op_contributes,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [VALUE_BITS-1:0] rsp_res_numer,
   output logic [VALUE_BITS-2:0] rsp_res_denom,
   output logic                  rsp_res_contributes,
   output logic [1:0]            rsp_order,
   output logic                  rsp_is_inverse,
   output logic                  rsp_is_unity,
   output logic                  rsp_error
);

   localparam int V  = VALUE_BITS;
   localparam int W  = 2 * VALUE_BITS + 2;

   reau_pkg::state_type state_ff, state_in;
   logic                 rv_ff, rv_in;
   logic [2:0]           kind_ff, kind_in;
   logic signed [W-1:0]  on_ff, on_in;
   logic signed [W-1:0]  od_ff, od_in;
   logic                 oc_ff, oc_in;
   logic signed [V-1:0]  an_ff, an_in;
   logic [V-1:0]         ad_ff, ad_in;
   logic                 ac_ff, ac_in;
   logic signed [W-1:0]  n_ff, n_in;
   logic signed [W-1:0]  d_ff, d_in;
   logic [W-1:0]         g_ff, g_in;
   logic                 ph_ff, ph_in;
   logic [1:0]           ord_ff, ord_in;
   logic                 inv_ff, inv_in;
   logic                 err_ff, err_in;
   logic signed [W-1:0]  p_ff, p_in;
   logic signed [W-1:0]  q_ff, q_in;

   reau_pkg::div_ctl_type dctl;
   reau_pkg::div_sts_type dsts;
   logic [W-1:0]         da, db, dquo, dres;
   logic [W-1:0]         n_abs;
   logic                 fits;
   logic signed [W-1:0]  lim;

   reau_divider #(.W(W)) u_div (
      .clock  (clock),
      .reset  (reset),
      .ctl    (dctl),
      .a      (da),
      .b      (db),
      .sts    (dsts),
      .quo    (dquo),
      .result (dres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= reau_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
         an_ff    <= '0;
         ad_ff    <= V'(1);
         ac_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         an_ff    <= an_in;
         ad_ff    <= ad_in;
         ac_ff    <= ac_in;
      end
      kind_ff <= kind_in;
      on_ff   <= on_in;
      od_ff   <= od_in;
      oc_ff   <= oc_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      g_ff    <= g_in;
      ph_ff   <= ph_in;
      ord_ff  <= ord_in;
      inv_ff  <= inv_in;
      err_ff  <= err_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
   end

   assign n_abs = n_ff[W-1] ? W'(-n_ff) : W'(n_ff);
   assign lim   = W'(1) <<< (V - 1);
   assign fits  = (n_ff >= -lim) && (n_ff < lim) && (d_ff >= W'(1)) && (d_ff < lim);

   always_comb begin
      state_in = state_ff;
      rv_in    = rv_ff;
      kind_in  = kind_ff;
      on_in    = on_ff;
      od_in    = od_ff;
      oc_in    = oc_ff;
      an_in    = an_ff;
      ad_in    = ad_ff;
      ac_in    = ac_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      g_in     = g_ff;
      ph_in    = ph_ff;
      ord_in   = ord_ff;
      inv_in   = inv_ff;
      err_in   = err_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      dctl.start = 1'b0;
      dctl.mode  = reau_pkg::DIV_GCD;
      da = n_abs;
      db = W'(d_ff);
      unique case (state_ff)
         reau_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               oc_in   = req_op_contributes;
               ord_in  = reau_pkg::ORDER_LESS;
               inv_in  = 1'b0;
               err_in  = 1'b0;
               p_in    = '0;
               if (req_op_denom[V-1]) begin
                  n_in = -W'(req_op_numer);
                  d_in = -W'(req_op_denom);
               end else begin
                  n_in = W'(req_op_numer);
                  d_in = W'(req_op_denom);
               end
               ph_in = 1'b0;
               if (req_kind > 3'(reau_pkg::KIND_INV)) begin
                  state_in = reau_pkg::ST_DONE;
               end else if (req_op_denom == '0) begin
                  err_in   = 1'b1;
                  state_in = reau_pkg::ST_DONE;
               end else begin
                  state_in = reau_pkg::ST_OPGCD;
               end
            end
         end
         reau_pkg::ST_OPGCD, reau_pkg::ST_RGCD: begin
            if (!ph_ff) begin
               dctl.start = 1'b1;
               ph_in = 1'b1;
            end else if (dsts.done) begin
               g_in  = dres;
               ph_in = 1'b0;
               state_in = (state_ff == reau_pkg::ST_OPGCD) ?
                          reau_pkg::ST_OPDIV : reau_pkg::ST_RDIV;
            end
         end
         reau_pkg::ST_OPDIV, reau_pkg::ST_RDIV: begin
            dctl.mode = reau_pkg::DIV_QUO;
            db = g_ff;
            if (g_ff <= W'(1)) begin
               state_in = (state_ff == reau_pkg::ST_OPDIV) ?
                          reau_pkg::ST_OPCHK : reau_pkg::ST_RCHK;
            end else if (!ph_ff) begin
               da = n_abs;
               dctl.start = 1'b1;
               ph_in = 1'b1;
            end else if (!dsts.busy && !dsts.done && p_ff == '0) begin
               ph_in = 1'b1;
            end else if (dsts.done) begin
               if (p_ff == '0) begin
                  n_in = n_ff[W-1] ? -W'(dquo) : W'(dquo);
                  p_in = W'(1);
                  da = W'(d_ff);
                  dctl.start = 1'b1;
               end else begin
                  d_in  = W'(dquo);
                  p_in  = '0;
                  ph_in = 1'b0;
                  g_in  = W'(1);
               end
            end
         end
         reau_pkg::ST_OPCHK: begin
            if (!fits) begin
               err_in   = 1'b1;
               state_in = reau_pkg::ST_DONE;
            end else begin
               on_in = n_ff;
               od_in = d_ff;
               unique case (kind_ff)
                  3'(reau_pkg::KIND_LOAD): begin
                     an_in = V'(n_ff);
                     ad_in = V'(d_ff);
                     ac_in = (n_ff != '0);
                     state_in = reau_pkg::ST_DONE;
                  end
                  3'(reau_pkg::KIND_ADD), 3'(reau_pkg::KIND_SUB): begin
                     n_in  = W'(ad_ff);
                     d_in  = d_ff;
                     ph_in = 1'b0;
                     state_in = reau_pkg::ST_DGCD;
                  end
                  3'(reau_pkg::KIND_MUL): begin
                     state_in = reau_pkg::ST_MUL;
                  end
                  default: begin
                     state_in = reau_pkg::ST_CMP;
                  end
               endcase
            end
         end
         reau_pkg::ST_DGCD: begin
            if (!ph_ff) begin
               dctl.start = 1'b1;
               ph_in = 1'b1;
            end else if (dsts.done) begin
               g_in  = dres;
               ph_in = 1'b0;
               p_in  = '0;
               state_in = reau_pkg::ST_LCM;
            end
         end
         reau_pkg::ST_LCM: begin
            dctl.mode = reau_pkg::DIV_QUO;
            db = g_ff;
            if (!ph_ff) begin
               da = W'(ad_ff);
               dctl.start = 1'b1;
               ph_in = 1'b1;
            end else if (dsts.done) begin
               if (p_ff == '0) begin
                  p_in = W'(dquo);
                  da = W'(od_ff);
                  dctl.start = 1'b1;
                  q_in = W'(1);
               end else begin
                  q_in = W'(dquo);
                  ph_in = 1'b0;
                  state_in = reau_pkg::ST_SUM;
               end
            end
         end
         reau_pkg::ST_SUM: begin
            if (!ph_ff) begin
               d_in  = p_ff * od_ff;
               ph_in = 1'b1;
            end else begin
               if (kind_ff == 3'(reau_pkg::KIND_ADD)) begin
                  n_in = W'(an_ff) * q_ff + on_ff * p_ff;
               end else begin
                  n_in = W'(an_ff) * q_ff - on_ff * p_ff;
               end
               p_in  = '0;
               ph_in = 1'b0;
               state_in = reau_pkg::ST_RGCD;
            end
         end
         reau_pkg::ST_MUL: begin
            n_in  = W'(an_ff) * on_ff;
            d_in  = W'(ad_ff) * od_ff;
            ph_in = 1'b0;
            p_in  = '0;
            state_in = reau_pkg::ST_RGCD;
         end
         reau_pkg::ST_RCHK: begin
            if (kind_ff != 3'(reau_pkg::KIND_MUL) && n_ff == '0) begin
               ac_in = 1'b0;
            end else if (!fits) begin
               err_in = 1'b1;
            end else begin
               an_in = V'(n_ff);
               ad_in = V'(d_ff);
               ac_in = (kind_ff == 3'(reau_pkg::KIND_MUL)) ?
                       (ac_ff && on_ff != '0) : 1'b1;
            end
            state_in = reau_pkg::ST_DONE;
         end
         reau_pkg::ST_CMP: begin
            p_in = W'(an_ff) * od_ff;
            q_in = on_ff * W'(ad_ff);
            if (ph_ff) begin
               if (kind_ff == 3'(reau_pkg::KIND_CMP)) begin
                  if (ac_ff != oc_ff) begin
                     ord_in = ac_ff ? reau_pkg::ORDER_GREATER : reau_pkg::ORDER_LESS;
                  end else if (p_ff < q_ff) begin
                     ord_in = reau_pkg::ORDER_LESS;
                  end else if (p_ff > q_ff) begin
                     ord_in = reau_pkg::ORDER_GREATER;
                  end else begin
                     ord_in = reau_pkg::ORDER_EQUAL;
                  end
               end else begin
                  inv_in = (ac_ff == oc_ff) && (p_ff == -q_ff);
               end
               ph_in = 1'b0;
               state_in = reau_pkg::ST_DONE;
            end else begin
               ph_in = 1'b1;
            end
         end
         reau_pkg::ST_DONE: begin
            p_in = '0;
            if (!rv_ff) begin
               rv_in = 1'b1;
            end else if (rsp_ready) begin
               rv_in = 1'b0;
               state_in = reau_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = reau_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready           = (state_ff == reau_pkg::ST_IDLE);
   assign rsp_valid           = rv_ff;
   assign rsp_res_numer       = an_ff;
   assign rsp_res_denom       = ad_ff[V-2:0];
   assign rsp_res_contributes = ac_ff;
   assign rsp_order           = ord_ff;
   assign rsp_is_inverse      = inv_ff;
   assign rsp_is_unity        = (an_ff == $signed(ad_ff));
   assign rsp_error           = err_ff;

endmodule

>>> tb/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB = 16;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [2:0]          kind;
      logic signed [VB-1:0] numer;
      logic signed [VB-1:0] denom;
      logic                contrib;
   } op_item_type;

   typedef struct packed {
      logic signed [VB-1:0] numer;
      logic [VB-2:0]        denom;
      logic                 contrib;
      logic [1:0]           order;
      logic                 inverse;
      logic                 unity;
      logic                 error;
   } acc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_kind = '0;
   logic signed [VB-1:0] req_op_numer = '0;
   logic signed [VB-1:0] req_op_denom = '0;
   logic req_op_contributes = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VB-1:0] rsp_res_numer;
   logic [VB-2:0] rsp_res_denom;
   logic rsp_res_contributes;
   logic [1:0] rsp_order;
   logic rsp_is_inverse;
   logic rsp_is_unity;
   logic rsp_error;

   op_item_type pending_ops[$];
   acc_result_type expected_results[$];
   int send_idle_pct = 22;
   int recv_idle_pct = 62;
   int mismatches = 0;
   int quiet_cycles = 0;
   bit req_fire = 1'b0;

   longint acc_n = 0;
   longint acc_d = 1;
   bit acc_c = 1'b0;

   rational_exponent_accumulator_unit #(.VALUE_BITS(VB)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint gcd_of(longint a, longint b);
      longint t;
      if (a < 0) a = -a;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic bit reduce_fits(ref longint n, ref longint d);
      longint g;
      longint lim;
      lim = longint'(1) << (VB - 1);
      g = gcd_of(n, d);
      if (g > 1) begin
         n = n / g;
         d = d / g;
      end
      return n >= -lim && n < lim && d >= 1 && d < lim;
   endfunction

   function automatic acc_result_type apply_op(op_item_type op);
      acc_result_type r;
      longint on, od, g, m, a, b, s, n, d;
      on = op.numer;
      od = op.denom;
      r = '0;
      if (op.kind <= reau_pkg::KIND_INV) begin
         if (od == 0) begin
            r.error = 1'b1;
         end else begin
            if (od < 0) begin
               od = -od;
               on = -on;
            end
            if (!reduce_fits(on, od)) begin
               r.error = 1'b1;
            end else begin
               case (reau_pkg::kind_type'(op.kind))
                  reau_pkg::KIND_LOAD: begin
                     acc_n = on;
                     acc_d = od;
                     acc_c = on != 0;
                  end
                  reau_pkg::KIND_ADD, reau_pkg::KIND_SUB: begin
                     g = gcd_of(acc_d, od);
                     m = (acc_d / g) * od;
                     a = acc_n * (m / acc_d);
                     b = on * (m / od);
                     s = (op.kind == reau_pkg::KIND_ADD) ? a + b : a - b;
                     if (s == 0) acc_c = 1'b0;
                     else if (!reduce_fits(s, m)) r.error = 1'b1;
                     else begin
                        acc_n = s;
                        acc_d = m;
                        acc_c = 1'b1;
                     end
                  end
                  reau_pkg::KIND_MUL: begin
                     n = acc_n * on;
                     d = acc_d * od;
                     if (!reduce_fits(n, d)) r.error = 1'b1;
                     else begin
                        acc_n = n;
                        acc_d = d;
                        acc_c = acc_c && on != 0;
                     end
                  end
                  reau_pkg::KIND_CMP: begin
                     if (acc_c != op.contrib)
                        r.order = acc_c ? reau_pkg::ORDER_GREATER : reau_pkg::ORDER_LESS;
                     else if (acc_n * od < on * acc_d) r.order = reau_pkg::ORDER_LESS;
                     else if (acc_n * od > on * acc_d) r.order = reau_pkg::ORDER_GREATER;
                     else r.order = reau_pkg::ORDER_EQUAL;
                  end
                  default: begin
                     r.inverse = acc_c == op.contrib && acc_n * od == -(on * acc_d);
                  end
               endcase
            end
         end
      end
      r.numer = acc_n[VB-1:0];
      r.denom = acc_d[VB-2:0];
      r.contrib = acc_c;
      r.unity = acc_n == acc_d;
      return r;
   endfunction

   function automatic op_item_type make_op(logic [2:0] k, longint n, longint d, bit c);
      op_item_type op;
      op.kind = k;
      op.numer = n[VB-1:0];
      op.denom = d[VB-1:0];
      op.contrib = c;
      return op;
   endfunction

   function automatic longint small_val();
      longint v;
      case ($urandom_range(0, 9))
         0: v = $signed(16'($urandom));
         1: v = $urandom_range(0, 1) ? 32767 : -32768;
         2, 3: v = longint'($urandom_range(0, 400)) - 200;
         default: v = longint'($urandom_range(0, 24)) - 12;
      endcase
      return v;
   endfunction

   function automatic longint acc_n_guess(longint n);
      return $urandom_range(0, 1) ? n : -n;
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (req_fire) void'(pending_ops.pop_front());
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_kind <= pending_ops[0].kind;
               req_op_numer <= pending_ops[0].numer;
               req_op_denom <= pending_ops[0].denom;
               req_op_contributes <= pending_ops[0].contrib;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
   end

   always @(posedge clock) begin
      acc_result_type exp_r;
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_op(make_op(req_kind, req_op_numer,
               req_op_denom, req_op_contributes)));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no expectation");
               mismatches++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_res_numer !== exp_r.numer) begin
                  $error("res_numer exp %0d got %0d", exp_r.numer, rsp_res_numer);
                  mismatches++;
               end
               if (rsp_res_denom !== exp_r.denom) begin
                  $error("res_denom exp %0d got %0d", exp_r.denom, rsp_res_denom);
                  mismatches++;
               end
               if (rsp_res_contributes !== exp_r.contrib) begin
                  $error("res_contributes exp %0d got %0d", exp_r.contrib,
                     rsp_res_contributes);
                  mismatches++;
               end
               if (rsp_order !== exp_r.order) begin
                  $error("order exp %0d got %0d", exp_r.order, rsp_order);
                  mismatches++;
               end
               if (rsp_is_inverse !== exp_r.inverse) begin
                  $error("is_inverse exp %0d got %0d", exp_r.inverse, rsp_is_inverse);
                  mismatches++;
               end
               if (rsp_is_unity !== exp_r.unity) begin
                  $error("is_unity exp %0d got %0d", exp_r.unity, rsp_is_unity);
                  mismatches++;
               end
               if (rsp_error !== exp_r.error) begin
                  $error("error exp %0d got %0d", exp_r.error, rsp_error);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      longint n, d;
      int k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      pending_ops.push_back(make_op(reau_pkg::KIND_CMP, 0, 1, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, 32767, 1, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_ADD, 1, 1, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, -32768, -1, 1));
      pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, -32768, 1, 1));
      pending_ops.push_back(make_op(reau_pkg::KIND_SUB, 0, 0, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, 6, -4, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_ADD, 3, 2, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, 1, 32767, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_ADD, 1, 32766, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, 3, 3, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_MUL, 200, 7, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_MUL, 300, 1, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_MUL, 0, -5, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, -2, 5, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_CMP, -1, 3, 1));
      pending_ops.push_back(make_op(reau_pkg::KIND_CMP, 4, -10, 1));
      pending_ops.push_back(make_op(reau_pkg::KIND_CMP, 1, 1, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_INV, 2, 5, 1));
      pending_ops.push_back(make_op(reau_pkg::KIND_INV, 2, 5, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_RSVD6, 1, 0, 1));
      pending_ops.push_back(make_op(reau_pkg::KIND_RSVD7, -1, -1, 0));
      pending_ops.push_back(make_op(reau_pkg::KIND_INV, 1, 0, 1));
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 62;
            recv_idle_pct = 22;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int i = 0; i < 210; i++) begin
            k = $urandom_range(0, 99);
            n = small_val();
            d = small_val();
            if ($urandom_range(0, 15) == 0) d = 0;
            else if (d == 0) d = 1;
            if (k < 14)
               pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, n, d, 1'($urandom)));
            else if (k < 36)
               pending_ops.push_back(make_op(reau_pkg::KIND_ADD, n, d, 1'($urandom)));
            else if (k < 56)
               pending_ops.push_back(make_op(reau_pkg::KIND_SUB, n, d, 1'($urandom)));
            else if (k < 70)
               pending_ops.push_back(make_op(reau_pkg::KIND_MUL, n, d, 1'($urandom)));
            else if (k < 82)
               pending_ops.push_back(make_op(reau_pkg::KIND_CMP, n, d, 1'($urandom)));
            else if (k < 86) pending_ops.push_back(make_op(3'($urandom_range(6, 7)),
               n, d, 1'($urandom)));
            else begin
               pending_ops.push_back(make_op(reau_pkg::KIND_INV, -acc_n_guess(n), d,
                  1'($urandom)));
            end
            if (k >= 95) pending_ops.push_back(make_op(reau_pkg::KIND_LOAD, 0, 1, 0));
         end
         while (pending_ops.size() > 0 || req_valid || expected_results.size() > 0)
            @(posedge clock);
      end
      repeat (50) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> rational_exponent_accumulator_unit.f
rtl/reau_pkg.sv
rtl/reau_divider.sv
rtl/rational_exponent_accumulator_unit.sv
tb/testbench.sv
